@@ rtl/cfu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfu_pkg
// Types and opcode constants shared by the control flow unit.
// ----------------------------------------------------------------------------
package cfu_pkg;

	localparam logic [7:0] OP_CB_PREFIX = 8'hcb;
	localparam logic [7:0] OP_JP        = 8'hc3;
	localparam logic [7:0] OP_JP_HL     = 8'he9;
	localparam logic [7:0] OP_JP_NZ     = 8'hc2;
	localparam logic [7:0] OP_JP_Z      = 8'hca;
	localparam logic [7:0] OP_JP_NC     = 8'hd2;
	localparam logic [7:0] OP_JP_C      = 8'hda;
	localparam logic [7:0] OP_JR        = 8'h18;
	localparam logic [7:0] OP_JR_NZ     = 8'h20;
	localparam logic [7:0] OP_JR_Z      = 8'h28;
	localparam logic [7:0] OP_JR_NC     = 8'h30;
	localparam logic [7:0] OP_JR_C      = 8'h38;
	localparam logic [7:0] OP_CALL      = 8'hcd;
	localparam logic [7:0] OP_CALL_NZ   = 8'hc4;
	localparam logic [7:0] OP_CALL_Z    = 8'hcc;
	localparam logic [7:0] OP_CALL_NC   = 8'hd4;
	localparam logic [7:0] OP_CALL_C    = 8'hdc;
	localparam logic [7:0] OP_RET       = 8'hc9;
	localparam logic [7:0] OP_RET_NZ    = 8'hc0;
	localparam logic [7:0] OP_RET_Z     = 8'hc8;
	localparam logic [7:0] OP_RET_NC    = 8'hd0;
	localparam logic [7:0] OP_RET_C     = 8'hd8;
	localparam logic [7:0] OP_RETI      = 8'hd9;
	localparam logic [7:0] OP_RST_00    = 8'hc7;
	localparam logic [7:0] OP_RST_08    = 8'hcf;
	localparam logic [7:0] OP_RST_10    = 8'hd7;
	localparam logic [7:0] OP_RST_18    = 8'hdf;
	localparam logic [7:0] OP_RST_20    = 8'he7;
	localparam logic [7:0] OP_RST_28    = 8'hef;
	localparam logic [7:0] OP_RST_30    = 8'hf7;
	localparam logic [7:0] OP_RST_38    = 8'hff;
	localparam logic [7:0] OP_DI_HALT   = 8'hf3;

	localparam logic [7:0]  IE_ALL_ON  = 8'hff;
	localparam logic [7:0]  IE_ALL_OFF = 8'h00;
	localparam logic [15:0] PC_RESET   = 16'h0000;
	localparam logic [15:0] SP_RESET   = 16'hfffe;
	localparam logic [15:0] SP_STEP    = 16'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_NOP,
		KIND_JUMP_ABS,
		KIND_JUMP_REL,
		KIND_CALL,
		KIND_RET,
		KIND_HALT
	} kind_t;

	// decoded operation passed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [1:0]  pc_adv;     // instruction length, 1..3
		logic [15:0] target;     // absolute target, or relative offset incl. length
		logic        ie_wr;
		logic [7:0]  ie_val;
		logic [15:0] stack_word;
	} op_t;

	typedef struct packed {
		logic [15:0] next_pc;
		logic [15:0] next_sp;
		logic        push_valid;
		logic [15:0] push_address;
		logic [15:0] push_data;
		logic        pop_used;
		logic        ie_write;
		logic [7:0]  ie_value;
		logic        halted;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/cfu_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfu_in_if / cfu_out_if
// Valid/ready channels for instructions in and control flow results out.
// ----------------------------------------------------------------------------
interface cfu_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  opcode;
	logic [15:0] operand;
	logic [15:0] hl_value;
	logic        zero_flag;
	logic        carry_flag;
	logic [15:0] stack_word;

	modport source (output valid, opcode, operand, hl_value, zero_flag, carry_flag,
		stack_word, input ready);
	modport sink (input valid, opcode, operand, hl_value, zero_flag, carry_flag,
		stack_word, output ready);
endinterface

interface cfu_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] next_pc;
	logic [15:0] next_sp;
	logic        push_valid;
	logic [15:0] push_address;
	logic [15:0] push_data;
	logic        pop_used;
	logic        ie_write;
	logic [7:0]  ie_value;
	logic        halted;

	modport source (output valid, next_pc, next_sp, push_valid, push_address, push_data,
		pop_used, ie_write, ie_value, halted, input ready);
	modport sink (input valid, next_pc, next_sp, push_valid, push_address, push_data,
		pop_used, ie_write, ie_value, halted, output ready);
endinterface
`default_nettype wire

@@ rtl/cfu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfu_front
// Instruction classification: length, kind, condition outcome and target.
// ----------------------------------------------------------------------------
module cfu_front
	import cfu_pkg::*;
(
	input  wire logic [7:0]  opcode,
	input  wire logic [15:0] operand,
	input  wire logic [15:0] hl_value,
	input  wire logic        zero_flag,
	input  wire logic        carry_flag,
	input  wire logic [15:0] stack_word,
	output op_t              op
);

	logic        cond;
	logic [15:0] rel_off;

	always_comb begin
		case (opcode[4:3])
			2'b00:   cond = ~zero_flag;
			2'b01:   cond = zero_flag;
			2'b10:   cond = ~carry_flag;
			default: cond = carry_flag;
		endcase
	end

	// sign-extended displacement plus the 2-byte JR length
	assign rel_off = {{8{operand[7]}}, operand[7:0]} + 16'd2;

	always_comb begin
		op.kind       = KIND_NOP;
		op.pc_adv     = 2'd1;
		op.target     = operand;
		op.ie_wr      = 1'b0;
		op.ie_val     = IE_ALL_OFF;
		op.stack_word = stack_word;
		case (opcode)
			OP_CB_PREFIX: op.pc_adv = 2'd2;
			OP_JP: begin
				op.pc_adv = 2'd3;
				op.kind   = KIND_JUMP_ABS;
			end
			OP_JP_HL: begin
				op.kind   = KIND_JUMP_ABS;
				op.target = hl_value;
			end
			OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: begin
				op.pc_adv = 2'd3;
				op.kind   = cond ? KIND_JUMP_ABS : KIND_NOP;
			end
			OP_JR: begin
				op.pc_adv = 2'd2;
				op.kind   = KIND_JUMP_REL;
				op.target = rel_off;
			end
			OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
				op.pc_adv = 2'd2;
				op.kind   = cond ? KIND_JUMP_REL : KIND_NOP;
				op.target = rel_off;
			end
			OP_CALL: begin
				op.pc_adv = 2'd3;
				op.kind   = KIND_CALL;
			end
			OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C: begin
				op.pc_adv = 2'd3;
				op.kind   = cond ? KIND_CALL : KIND_NOP;
			end
			OP_RET: op.kind = KIND_RET;
			OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C:
				op.kind = cond ? KIND_RET : KIND_NOP;
			OP_RETI: begin
				op.kind   = KIND_RET;
				op.ie_wr  = 1'b1;
				op.ie_val = IE_ALL_ON;
			end
			OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
			OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38: begin
				op.kind   = KIND_CALL;
				op.target = {10'd0, opcode[5:3], 3'd0};
			end
			OP_DI_HALT: begin
				op.kind   = KIND_HALT;
				op.ie_wr  = 1'b1;
				op.ie_val = IE_ALL_OFF;
			end
			default: op.kind = KIND_NOP;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/cfu_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfu_queue
// Short FIFO of decoded operations between front and back.
// ----------------------------------------------------------------------------
module cfu_queue
	import cfu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire op_t  wr_op,
	output logic      full,
	input  wire logic rd_en,
	output op_t       rd_op,
	output logic      not_empty
);

	op_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_op     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cfu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfu_back
// Holds PC, SP and halt state, executes decoded operations, registers result.
// ----------------------------------------------------------------------------
module cfu_back
	import cfu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic op_valid,
	input  wire op_t  op,
	output logic      op_take,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	logic [15:0] pc_q;
	logic [15:0] sp_q;
	logic        halt_q;
	logic        res_valid_q;
	res_t        res_q;
	res_t        res_d;
	logic [15:0] pc_adv;

	assign op_take   = op_valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign pc_adv    = pc_q + {14'd0, op.pc_adv};

	always_comb begin
		res_d              = '0;
		res_d.next_pc      = pc_q;
		res_d.next_sp      = sp_q;
		res_d.halted       = halt_q;
		if (!halt_q) begin
			res_d.next_pc  = pc_adv;
			res_d.ie_write = op.ie_wr;
			res_d.ie_value = op.ie_wr ? op.ie_val : IE_ALL_OFF;
			case (op.kind)
				KIND_JUMP_ABS: res_d.next_pc = op.target;
				KIND_JUMP_REL: res_d.next_pc = pc_q + op.target;
				KIND_CALL: begin
					res_d.next_pc      = op.target;
					res_d.next_sp      = sp_q - SP_STEP;
					res_d.push_valid   = 1'b1;
					res_d.push_address = sp_q - SP_STEP;
					res_d.push_data    = pc_adv;
				end
				KIND_RET: begin
					res_d.next_pc  = op.stack_word;
					res_d.next_sp  = sp_q + SP_STEP;
					res_d.pop_used = 1'b1;
				end
				KIND_HALT: res_d.halted = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (op_take)
			res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_RESET;
			sp_q        <= SP_RESET;
			halt_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (op_take) begin
				pc_q   <= res_d.next_pc;
				sp_q   <= res_d.next_sp;
				halt_q <= res_d.halted;
			end
			if (op_take)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ rtl/sm83_control_flow_unit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83_control_flow_unit_core
// SM83 control flow unit: PC, SP and halt tracking for jumps, calls, returns.
//
// Channels: in_ch takes one instruction per transaction (opcode, fetched
// immediate, HL, Z and C flags, word at the stack top). out_ch gives one
// result per instruction: new PC and SP, stack push, pop use, IE write and
// the halted flag. Both use valid/ready; a transaction completes when both
// are high at a rising edge of clk.
// Path: an input transaction is decoded into a 2-entry queue, then executed
// into the output register.
// Throughput: one instruction per cycle while out_ch does not stall; the PC/SP
// update loop closes within the back end registers.
// Reset (arst_n low): PC = 0x0000, SP = 0xfffe, running, queue and output
// empty. When out_ch stalls, the output register holds its result, the
// queue fills, and in_ch.ready drops once both queue entries are taken.
// ----------------------------------------------------------------------------
module sm83_control_flow_unit_core
	import cfu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	cfu_in_if.sink    in_ch,
	cfu_out_if.source out_ch
);

	op_t  dec_op;
	op_t  head_op;
	logic q_full;
	logic q_not_empty;
	logic q_take;
	res_t res;

	cfu_front u_front (
		.opcode     (in_ch.opcode),
		.operand    (in_ch.operand),
		.hl_value   (in_ch.hl_value),
		.zero_flag  (in_ch.zero_flag),
		.carry_flag (in_ch.carry_flag),
		.stack_word (in_ch.stack_word),
		.op         (dec_op)
	);

	assign in_ch.ready = !q_full;

	cfu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_ch.valid && !q_full),
		.wr_op     (dec_op),
		.full      (q_full),
		.rd_en     (q_take),
		.rd_op     (head_op),
		.not_empty (q_not_empty)
	);

	cfu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_not_empty),
		.op        (head_op),
		.op_take   (q_take),
		.res_valid (out_ch.valid),
		.res_ready (out_ch.ready),
		.res       (res)
	);

	assign out_ch.next_pc      = res.next_pc;
	assign out_ch.next_sp      = res.next_sp;
	assign out_ch.push_valid   = res.push_valid;
	assign out_ch.push_address = res.push_address;
	assign out_ch.push_data    = res.push_data;
	assign out_ch.pop_used     = res.pop_used;
	assign out_ch.ie_write     = res.ie_write;
	assign out_ch.ie_value     = res.ie_value;
	assign out_ch.halted       = res.halted;

endmodule
`default_nettype wire

@@ dv/tb_sm83_control_flow_unit_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sm83_control_flow_unit_core
// Checks PC, SP, stack push/pop, IE writes and halt tracking of the SM83
// control flow unit against a cycle-free model of the instruction set.
// A directed pass walks the wrap-around corners and every branch family
// with its condition both met and not met. Random phases follow, mostly
// control flow opcodes, under varied source idling and sink stalls.
// The run ends by halting the unit and sending instructions that must be
// ignored.
// ----------------------------------------------------------------------------
module tb_sm83_control_flow_unit_core;
	import cfu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {CC_NZ, CC_Z, CC_NC, CC_C} cc_t;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [15:0] operand;
		logic [15:0] hl_value;
		logic        zero_flag;
		logic        carry_flag;
		logic [15:0] stack_word;
	} instr_t;

	logic clk;
	logic arst_n;

	cfu_in_if  in_ch ();
	cfu_out_if out_ch ();

	sm83_control_flow_unit_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// architectural state tracked by the testbench
	logic [15:0] arch_pc;
	logic [15:0] arch_sp;
	logic        arch_halted;

	res_t expected_results[$];
	res_t exp_r;

	int src_idle_pct;
	int snk_stall_pct;
	int n_errors;
	int n_sent;
	int n_checked;
	int n_pushes;
	int n_pops;
	int cycle_count;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic cond_met(instr_t it);
		case (cc_t'(it.opcode[4:3]))
			CC_NZ: return !it.zero_flag;
			CC_Z: return it.zero_flag;
			CC_NC: return !it.carry_flag;
			default: return it.carry_flag;
		endcase
	endfunction

	function automatic logic is_flow(logic [7:0] op);
		case (op)
			OP_JP, OP_JP_HL, OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C,
			OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C,
			OP_CALL, OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C,
			OP_RET, OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C, OP_RETI,
			OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
			OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic instr_t make_instr(logic [7:0] op, logic [15:0] imm,
		logic [15:0] hl, logic z, logic c, logic [15:0] top);
		instr_t it;
		it.opcode     = op;
		it.operand    = imm;
		it.hl_value   = hl;
		it.zero_flag  = z;
		it.carry_flag = c;
		it.stack_word = top;
		return it;
	endfunction

	function automatic instr_t rand_fields(logic [7:0] op);
		return make_instr(op, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
			1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom_range(65535)));
	endfunction

	// mostly branch/call/return traffic; never the halting opcode
	function automatic instr_t rand_instr();
		logic [7:0] op;
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			op = OP_CB_PREFIX;
		end else begin
			do op = 8'($urandom_range(255));
			while (op == OP_DI_HALT || (pick < 75 && !is_flow(op)));
		end
		return rand_fields(op);
	endfunction

	function automatic instr_t with_condition(instr_t it, logic taken);
		instr_t r;
		r = it;
		case (cc_t'(it.opcode[4:3]))
			CC_NZ: r.zero_flag = !taken;
			CC_Z: r.zero_flag = taken;
			CC_NC: r.carry_flag = !taken;
			default: r.carry_flag = taken;
		endcase
		return r;
	endfunction

	task automatic predict_flow(input instr_t it);
		res_t r;
		logic [15:0] pc;
		logic [15:0] sp;
		logic [15:0] target;
		logic do_jump;
		logic do_call;
		logic do_ret;
		r = '0;
		pc = arch_pc;
		sp = arch_sp;
		target = '0;
		do_jump = 1'b0;
		do_call = 1'b0;
		do_ret = 1'b0;
		if (!arch_halted) begin
			if (it.opcode == OP_CB_PREFIX) begin
				pc = pc + 16'd2;
			end else begin
				pc = pc + 16'd1;
				case (it.opcode)
					OP_JP: begin
						pc = pc + 16'd2;
						do_jump = 1'b1;
						target = it.operand;
					end
					OP_JP_HL: begin
						do_jump = 1'b1;
						target = it.hl_value;
					end
					OP_JP_NZ, OP_JP_Z, OP_JP_NC, OP_JP_C: begin
						pc = pc + 16'd2;
						do_jump = cond_met(it);
						target = it.operand;
					end
					OP_JR, OP_JR_NZ, OP_JR_Z, OP_JR_NC, OP_JR_C: begin
						pc = pc + 16'd1;
						if (it.opcode == OP_JR || cond_met(it)) begin
							do_jump = 1'b1;
							target = pc + {{8{it.operand[7]}}, it.operand[7:0]};
						end
					end
					OP_CALL: begin
						pc = pc + 16'd2;
						do_call = 1'b1;
						target = it.operand;
					end
					OP_CALL_NZ, OP_CALL_Z, OP_CALL_NC, OP_CALL_C: begin
						pc = pc + 16'd2;
						do_call = cond_met(it);
						target = it.operand;
					end
					OP_RET: do_ret = 1'b1;
					OP_RET_NZ, OP_RET_Z, OP_RET_NC, OP_RET_C: do_ret = cond_met(it);
					OP_RETI: begin
						do_ret = 1'b1;
						r.ie_write = 1'b1;
						r.ie_value = IE_ALL_ON;
					end
					OP_RST_00, OP_RST_08, OP_RST_10, OP_RST_18,
					OP_RST_20, OP_RST_28, OP_RST_30, OP_RST_38: begin
						do_call = 1'b1;
						target = {10'd0, it.opcode[5:3], 3'd0};
					end
					OP_DI_HALT: begin
						r.ie_write = 1'b1;
						r.ie_value = IE_ALL_OFF;
						arch_halted = 1'b1;
					end
					default: ;
				endcase
				if (do_call) begin
					sp = sp - SP_STEP;
					r.push_valid = 1'b1;
					r.push_address = sp;
					r.push_data = pc;
					pc = target;
				end else if (do_ret) begin
					r.pop_used = 1'b1;
					pc = it.stack_word;
					sp = sp + SP_STEP;
				end else if (do_jump) begin
					pc = target;
				end
			end
			arch_pc = pc;
			arch_sp = sp;
		end
		r.next_pc = arch_pc;
		r.next_sp = arch_sp;
		r.halted = arch_halted;
		expected_results.push_back(r);
	endtask

	// called at a rising edge; returns at the edge where the transaction completes
	task automatic send_instr(input instr_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.opcode     <= it.opcode;
		in_ch.operand    <= it.operand;
		in_ch.hl_value   <= it.hl_value;
		in_ch.zero_flag  <= it.zero_flag;
		in_ch.carry_flag <= it.carry_flag;
		in_ch.stack_word <= it.stack_word;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_flow(it);
		n_sent++;
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_idling(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic test_directed_flow();
		logic [7:0] cond_bases [4];
		logic [1:0] ccv;
		instr_t it;
		cond_bases = '{OP_JP_NZ, OP_JR_NZ, OP_CALL_NZ, OP_RET_NZ};
		send_instr(make_instr(8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000));
		// SP wraps upward on a pop from 0xfffe, then back down on the call
		send_instr(make_instr(OP_RET, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0100));
		send_instr(make_instr(OP_CALL, 16'hfffe, 16'h0000, 1'b1, 1'b1, 16'hffff));
		send_instr(make_instr(OP_CB_PREFIX, 16'hffff, 16'hffff, 1'b1, 1'b1, 16'hffff));
		send_instr(make_instr(OP_JP_HL, 16'h0000, 16'hffff, 1'b0, 1'b0, 16'h0000));
		send_instr(make_instr(8'h7f, 16'hffff, 16'hffff, 1'b1, 1'b1, 16'hffff));
		// most negative and most positive JR offsets, high operand byte ignored
		send_instr(make_instr(OP_JR, 16'hff80, 16'h0000, 1'b0, 1'b0, 16'h0000));
		send_instr(make_instr(OP_JR, 16'h007f, 16'h0000, 1'b0, 1'b0, 16'h0000));
		send_instr(make_instr(OP_JP, 16'h0000, 16'hffff, 1'b1, 1'b0, 16'h0000));
		send_instr(make_instr(OP_RST_38, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000));
		send_instr(make_instr(OP_RST_00, 16'hffff, 16'h0000, 1'b0, 1'b0, 16'h0000));
		send_instr(make_instr(OP_RETI, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'hffff));
		send_instr(make_instr(OP_RET, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000));
		for (int f = 0; f < 4; f++) begin
			for (int cc = 0; cc < 4; cc++) begin
				ccv = 2'(cc);
				it = rand_fields({cond_bases[f][7:5], ccv, cond_bases[f][2:0]});
				send_instr(with_condition(it, ccv[0] ^ f[0]));
			end
		end
		wait_drain();
	endtask

	task automatic test_random_flow(input int n_items);
		for (int i = 0; i < n_items; i++) send_instr(rand_instr());
		wait_drain();
	endtask

	// once halted nothing changes, so this runs last
	task automatic test_halt();
		send_instr(rand_fields(OP_DI_HALT));
		for (int i = 0; i < 24; i++) send_instr(rand_fields(8'($urandom_range(255))));
		send_instr(rand_fields(OP_DI_HALT));
		send_instr(rand_fields(OP_CB_PREFIX));
		wait_drain();
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transaction with no instruction outstanding");
				n_errors++;
			end else begin
				exp_r = expected_results.pop_front();
				check_field("next_pc", exp_r.next_pc, out_ch.next_pc);
				check_field("next_sp", exp_r.next_sp, out_ch.next_sp);
				check_field("push_valid", 16'(exp_r.push_valid), 16'(out_ch.push_valid));
				check_field("push_address", exp_r.push_address, out_ch.push_address);
				check_field("push_data", exp_r.push_data, out_ch.push_data);
				check_field("pop_used", 16'(exp_r.pop_used), 16'(out_ch.pop_used));
				check_field("ie_write", 16'(exp_r.ie_write), 16'(out_ch.ie_write));
				check_field("ie_value", 16'(exp_r.ie_value), 16'(out_ch.ie_value));
				check_field("halted", 16'(exp_r.halted), 16'(out_ch.halted));
				n_pushes += exp_r.push_valid;
				n_pops += exp_r.pop_used;
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.operand = '0;
		in_ch.hl_value = '0;
		in_ch.zero_flag = 1'b0;
		in_ch.carry_flag = 1'b0;
		in_ch.stack_word = '0;
		out_ch.ready = 1'b0;
		arch_pc = PC_RESET;
		arch_sp = SP_RESET;
		arch_halted = 1'b0;
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_pushes = 0;
		n_pops = 0;
		cycle_count = 0;
		set_idling(0, 0);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_flow();
		set_idling(0, 0);
		test_random_flow(285);
		set_idling(70, 0);
		test_random_flow(285);
		set_idling(0, 70);
		test_random_flow(285);
		set_idling(22, 22);
		test_random_flow(285);
		test_halt();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d instructions: jumps, relative jumps, calls, returns, RST, CB, NOPs,",
			n_sent);
		$display("then halt; %0d results checked with %0d pushes and %0d pops, four idle mixes",
			n_checked, n_pushes, n_pops);
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
